>>> hw/rtl/opp_pkg.sv
// Shared constants and types of the orthographic point projection core.
// No dependencies; compiled first.
`default_nettype none

package opp_pkg;

  // Quotient bits resolved in each divider pipeline stage.
  localparam int OPP_SPS = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAR    = 3'd5;

  // Status of one axis as it leaves the divider.
  typedef struct packed {
    logic zero_span;
    logic saturated;
  } opp_flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/opp_if.sv
// Request and result channel interfaces of the projection core.
// Depends on nothing; compiled after opp_pkg.
`default_nettype none

interface opp_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface opp_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic [2:0]                    zero_span_flags;
  logic [2:0]                    saturated_flags;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output zero_span_flags, output saturated_flags, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input zero_span_flags, input saturated_flags, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/opp_div.sv
// Pipelined signed fixed point divider with truncation and saturation.
// Depends on opp_pkg.
`default_nettype none

module opp_div
  import opp_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [COORD_WIDTH+1:0] num,
  input  wire logic signed [COORD_WIDTH:0]   den,
  output      logic [COORD_WIDTH-1:0]        res,
  output      opp_flags_t                    flags
);

  localparam int CW   = COORD_WIDTH;
  localparam int NW   = CW + 2;
  localparam int DW   = CW + 1;
  localparam int DVW  = CW + 2 + FRAC_BITS;
  localparam int RW   = CW + 2;
  localparam int CMPW = CW + DW;
  localparam int NSTG = (CW + OPP_SPS - 1) / OPP_SPS;

  // Stage 1: magnitudes and signs.
  logic [NW-1:0] an_r;
  logic [DW-1:0] ad1_r;
  logic          neg1_r, zero1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      an_r    <= num[NW-1] ? NW'(-num) : NW'(num);
      ad1_r   <= den[DW-1] ? DW'(-den) : DW'(den);
      neg1_r  <= num[NW-1] ^ den[DW-1];
      zero1_r <= (den == '0);
    end
  end

  // Stage 2: overflow test and the initial partial remainder.
  logic [DVW-1:0] sdv_r  [NSTG+1];
  logic [DW-1:0]  sad_r  [NSTG+1];
  logic [RW-1:0]  srem_r [NSTG+1];
  logic [CW-1:0]  sq_r   [NSTG+1];
  logic           sneg_r [NSTG+1];
  logic           szero_r[NSTG+1];
  logic           sover_r[NSTG+1];

  logic [DVW-1:0] dv;
  assign dv = DVW'(an_r) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      sdv_r[0]   <= dv;
      sad_r[0]   <= ad1_r;
      srem_r[0]  <= RW'(dv >> CW);
      sq_r[0]    <= '0;
      sneg_r[0]  <= neg1_r;
      szero_r[0] <= zero1_r;
      sover_r[0] <= (CMPW'(an_r) << FRAC_BITS) >= (CMPW'(ad1_r) << CW);
    end
  end

  // Restoring division, OPP_SPS quotient bits per stage.
  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic [RW-1:0] rem;
    logic [CW-1:0] q;

    always_comb begin
      logic qb;
      rem = srem_r[k];
      q   = sq_r[k];
      qb  = 1'b0;
      for (int s = 0; s < OPP_SPS; s++) begin
        if (k * OPP_SPS + s < CW) begin
          rem = {rem[RW-2:0], sdv_r[k][CW-1-(k*OPP_SPS+s)]};
          qb  = (rem >= RW'(sad_r[k]));
          if (qb) begin
            rem = rem - RW'(sad_r[k]);
          end
          q = {q[CW-2:0], qb};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sdv_r[k+1]   <= sdv_r[k];
        sad_r[k+1]   <= sad_r[k];
        srem_r[k+1]  <= rem;
        sq_r[k+1]    <= q;
        sneg_r[k+1]  <= sneg_r[k];
        szero_r[k+1] <= szero_r[k];
        sover_r[k+1] <= sover_r[k];
      end
    end
  end

  // Final stage: clamp, restore the sign, flag.
  logic [CW-1:0] lim;
  logic          sat;
  logic          fneg, fzero;

  assign fneg  = sneg_r[NSTG];
  assign fzero = szero_r[NSTG];
  assign lim   = fneg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  assign sat   = sover_r[NSTG] || (sq_r[NSTG] > lim);

  always_ff @(posedge clk) begin
    if (en) begin
      if (fzero) begin
        res <= '0;
      end else if (sat) begin
        res <= fneg ? CW'(-lim) : lim;
      end else begin
        res <= fneg ? CW'(-sq_r[NSTG]) : sq_r[NSTG];
      end
      flags.zero_span <= fzero;
      flags.saturated <= !fzero && sat;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/orthographic_point_projection_core.sv
// Top level of the orthographic point projection core.
// Depends on opp_pkg, opp_if (opp_in_if, opp_out_if) and opp_div.
`default_nettype none

// Maps each requested point (x, y, z) into normalised device coordinates of
// the viewport box held in six configuration registers: x' = (2x-(l+r))/(r-l),
// y' = (2y-(t+b))/(t-b) and z' = (-2z+(f+n))/(f-n), all signed fixed point
// with FRAC_BITS fraction bits. Quotients truncate toward zero and saturate;
// an axis whose span is zero yields 0 and raises its zero_span_flags bit.
// The core accepts one request per clock while the output is not stalled,
// and returns one result per request, in order, from three parallel divider
// pipelines which resolve four quotient bits per stage.
// The whole pipeline advances whenever the output register is empty or
// being taken, so a stall at the output holds every stage in place.
// Configuration should be written only while no request is in flight; the
// derived span and offset registers update in the cycle after the write.

module orthographic_point_projection_core
  import opp_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [COORD_WIDTH-1:0] cfg_data,
  opp_in_if.sink                      in_req,
  opp_out_if.source                   out_rsp
);

  localparam int CW      = COORD_WIDTH;
  localparam int NSTG    = (CW + OPP_SPS - 1) / OPP_SPS;
  localparam int DIV_LAT = 3 + NSTG;
  localparam int LAT     = 1 + DIV_LAT;

  // Configuration registers, reset to the box from -1.0 to +1.0.
  localparam logic [CW-1:0] ONE  = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] MONE = CW'(-(CW'(1) << FRAC_BITS));

  logic signed [CW-1:0] left_r, right_r, bottom_r, top_r, near_r, far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= MONE;
      right_r  <= ONE;
      bottom_r <= MONE;
      top_r    <= ONE;
      near_r   <= MONE;
      far_r    <= ONE;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LEFT:   left_r   <= cfg_data;
        REG_RIGHT:  right_r  <= cfg_data;
        REG_BOTTOM: bottom_r <= cfg_data;
        REG_TOP:    top_r    <= cfg_data;
        REG_NEAR:   near_r   <= cfg_data;
        REG_FAR:    far_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Offsets and spans of the box are held in registers of their own, so the
  // request path sees a single subtraction per axis.
  logic signed [CW:0] xsum_r, ysum_r, zsum_r;
  logic signed [CW:0] xspan_r, yspan_r, zspan_r;

  always_ff @(posedge clk) begin
    xsum_r  <= (CW+1)'(left_r)   + (CW+1)'(right_r);
    ysum_r  <= (CW+1)'(bottom_r) + (CW+1)'(top_r);
    zsum_r  <= (CW+1)'(near_r)   + (CW+1)'(far_r);
    xspan_r <= (CW+1)'(right_r)  - (CW+1)'(left_r);
    yspan_r <= (CW+1)'(top_r)    - (CW+1)'(bottom_r);
    zspan_r <= (CW+1)'(far_r)    - (CW+1)'(near_r);
  end

  // Pipeline advance: everything moves when the output register is free.
  logic           en;
  logic [LAT-1:0] vld_r;

  assign en           = !vld_r[LAT-1] || out_rsp.ready;
  assign in_req.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_req.valid};
    end
  end

  // First stage: numerators. The z numerator has its sign flipped.
  logic signed [CW+1:0] xnum_r, ynum_r, znum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xnum_r <= $signed({in_req.in_x[CW-1], in_req.in_x, 1'b0})
                - $signed({xsum_r[CW], xsum_r});
      ynum_r <= $signed({in_req.in_y[CW-1], in_req.in_y, 1'b0})
                - $signed({ysum_r[CW], ysum_r});
      znum_r <= $signed({zsum_r[CW], zsum_r})
                - $signed({in_req.in_z[CW-1], in_req.in_z, 1'b0});
    end
  end

  // One divider pipeline per axis; the last divider stage is the output
  // register.
  logic [CW-1:0] xres, yres, zres;
  opp_flags_t    xflg, yflg, zflg;

  opp_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .en(en), .num(xnum_r), .den(xspan_r), .res(xres), .flags(xflg)
  );

  opp_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .en(en), .num(ynum_r), .den(yspan_r), .res(yres), .flags(yflg)
  );

  opp_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk(clk), .en(en), .num(znum_r), .den(zspan_r), .res(zres), .flags(zflg)
  );

  assign out_rsp.valid           = vld_r[LAT-1];
  assign out_rsp.out_x           = xres;
  assign out_rsp.out_y           = yres;
  assign out_rsp.out_z           = zres;
  assign out_rsp.zero_span_flags = {zflg.zero_span, yflg.zero_span, xflg.zero_span};
  assign out_rsp.saturated_flags = {zflg.saturated, yflg.saturated, xflg.saturated};

endmodule

`default_nettype wire
